// ----- rtl/lnr_pkg.sv -----
// ----------------------------------------------------------------------------
// lnr_pkg
// Shared types and constants of the layer-normalization row engine.
// ----------------------------------------------------------------------------
package lnr_pkg;

   // Default and fixed sizes
   localparam int MAX_ROW_DEF = 64;
   localparam int SAMPLE_W    = 16;
   localparam int COL_W       = 6;
   localparam int LEN_W       = 7;
   localparam int EPS_W       = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;

   // Divider operand widths
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON    = 1'b1;

   // Item actions
   localparam logic ACT_TABLE  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   typedef struct packed {
      logic                       action;
      logic [COL_W-1:0]           column;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [15:0]         gamma_value;
      logic signed [15:0]         beta_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] normalized;
      logic [COL_W-1:0]           out_column;
      logic                       row_end;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/lnr_queue.sv -----
// ----------------------------------------------------------------------------
// lnr_queue
// Front queue: takes items from the input channel and holds them for the core.
// ----------------------------------------------------------------------------
module lnr_queue
   import lnr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_stall,
   input  req_type push_data,
   output logic    pop_valid,
   input  logic    pop_en,
   output req_type pop_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   req_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign push_stall = (count_ff == CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_en && pop_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/lnr_div.sv -----
// ----------------------------------------------------------------------------
// lnr_div
// Restoring divider, one quotient bit per cycle, shared by the core.
// ----------------------------------------------------------------------------
module lnr_div
   import lnr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(DIV_NUM_W);

   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 fits;

   // One restoring step
   always_comb begin
      rem_sh  = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
      fits    = (rem_sh >= {1'b0, den_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_in  = {quo_ff[DIV_NUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- rtl/lnr_core.sv -----
// ----------------------------------------------------------------------------
// lnr_core
// Back end: table and row buffer writes, mean, variance, inverse square root
// and per-column output of a finished row.
// ----------------------------------------------------------------------------
module lnr_core
   import lnr_pkg::*;
#(
   parameter int MAX_ROW = MAX_ROW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  item_valid,
   output logic                  item_pop,
   input  req_type               item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_MEAN_GO   = 5'd1;
   localparam logic [4:0] ST_MEAN_WAIT = 5'd2;
   localparam logic [4:0] ST_VAR_RD    = 5'd3;
   localparam logic [4:0] ST_VAR_SQ    = 5'd4;
   localparam logic [4:0] ST_VAR_ACC   = 5'd5;
   localparam logic [4:0] ST_VAR_GO    = 5'd6;
   localparam logic [4:0] ST_VAR_WAIT  = 5'd7;
   localparam logic [4:0] ST_SQRT      = 5'd8;
   localparam logic [4:0] ST_INV_GO    = 5'd9;
   localparam logic [4:0] ST_INV_WAIT  = 5'd10;
   localparam logic [4:0] ST_OUT_RD    = 5'd11;
   localparam logic [4:0] ST_OUT_MAG   = 5'd12;
   localparam logic [4:0] ST_OUT_LO    = 5'd13;
   localparam logic [4:0] ST_OUT_HI    = 5'd14;
   localparam logic [4:0] ST_OUT_Y     = 5'd15;
   localparam logic [4:0] ST_OUT_EMIT  = 5'd16;

   localparam logic [56:0] VE_LIM = 57'((64'd1 << 50) - 64'd1);

   // Memories
   logic signed [15:0] buf_mem   [MAX_ROW];
   logic signed [15:0] gamma_mem [MAX_ROW];
   logic signed [15:0] beta_mem  [MAX_ROW];
   logic signed [15:0] buf_rd_ff, gamma_rd_ff, beta_rd_ff;

   // Control and datapath registers
   logic [4:0]          state_ff, state_in;
   logic [LEN_W-1:0]    row_length_ff;
   logic [EPS_W-1:0]    epsilon_ff;
   logic signed [21:0]  sum_ff, sum_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    col_ff, col_in;
   logic signed [24:0]  mean_ff, mean_in;
   logic [49:0]         sq_ff, sq_in;
   logic [55:0]         sumsq_ff, sumsq_in;
   logic [63:0]         sqv_ff, sqv_in;
   logic [63:0]         res_ff, res_in;
   logic [63:0]         bit_ff, bit_in;
   logic [4:0]          step_ff, step_in;
   logic [46:0]         inv_ff, inv_in;
   logic [24:0]         mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [48:0]         pplo_ff, pplo_in;
   logic [47:0]         pphi_ff, pphi_in;
   logic signed [48:0]  y_ff, y_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Combinational helpers
   logic [LEN_W-1:0]    n_len;
   logic [LEN_W-1:0]    fill_next;
   logic                buf_we, tab_we;
   logic [21:0]         sum_abs;
   logic signed [25:0]  x_scaled, d_val;
   logic [24:0]         d_mag;
   logic [56:0]         ve_sum;
   logic [49:0]         ve;
   logic [63:0]         trial;
   logic [31:0]         s_fix;
   logic [49:0]         xh_sum;
   logic [31:0]         xh_mag;
   logic signed [32:0]  xh;
   logic [48:0]         y_mag;
   logic [28:0]         y_rnd;
   logic signed [15:0]  y_sat;
   logic                emit_ok, last_col;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   lnr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= LEN_W'(64);
         epsilon_ff    <= EPS_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROW_LENGTH: row_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_EPSILON:    epsilon_ff    <= csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp row length to the range from 2 to the buffer depth
   always_comb begin
      if (row_length_ff < LEN_W'(2)) begin
         n_len = LEN_W'(2);
      end else if (row_length_ff > LEN_W'(MAX_ROW)) begin
         n_len = LEN_W'(MAX_ROW);
      end else begin
         n_len = row_length_ff;
      end
   end

   assign item_pop  = (state_ff == ST_IDLE) && item_valid;
   assign buf_we    = item_pop && (item.action == ACT_SAMPLE);
   assign tab_we    = item_pop && (item.action == ACT_TABLE)
                      && ({1'b0, item.column} < LEN_W'(MAX_ROW));
   assign fill_next = fill_ff + LEN_W'(1);

   // Memory writes and registered reads
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[fill_ff[AW-1:0]] <= item.sample;
      end
      if (tab_we) begin
         gamma_mem[item.column[AW-1:0]] <= item.gamma_value;
         beta_mem[item.column[AW-1:0]]  <= item.beta_value;
      end
      buf_rd_ff   <= buf_mem[col_ff[AW-1:0]];
      gamma_rd_ff <= gamma_mem[col_ff[AW-1:0]];
      beta_rd_ff  <= beta_mem[col_ff[AW-1:0]];
   end

   // Datapath helpers
   always_comb begin
      sum_abs  = sum_ff[21] ? 22'(-sum_ff) : 22'(sum_ff);
      x_scaled = {{2{buf_rd_ff[15]}}, buf_rd_ff, 8'b0};
      d_val    = x_scaled - {mean_ff[24], mean_ff};
      d_mag    = d_val[25] ? 25'(-d_val) : d_val[24:0];
      ve_sum   = 57'(div_rsp.quotient[55:0]) + 57'({epsilon_ff, 16'b0});
      ve       = (ve_sum > VE_LIM) ? VE_LIM[49:0] : ve_sum[49:0];
      trial    = res_ff + bit_ff;
      s_fix    = (res_ff[31:0] == '0) ? 32'd1 : res_ff[31:0];
      xh_sum   = 50'(pphi_ff) + 50'((50'(pplo_ff) + 50'(1 << 23)) >> 24);
      xh_mag   = (xh_sum > 50'(64'd1 << 31)) ? 32'h8000_0000 : xh_sum[31:0];
      xh       = neg_ff ? -$signed({1'b0, xh_mag}) : $signed({1'b0, xh_mag});
      y_mag    = y_ff[48] ? 49'(-y_ff) : 49'(y_ff);
      y_rnd    = 29'((y_mag + 49'(1 << 19)) >> 20);
      if (y_ff[48]) begin
         y_sat = (y_rnd > 29'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, y_rnd}));
      end else begin
         y_sat = (y_rnd > 29'd32767) ? 16'sd32767 : 16'(y_rnd);
      end
      emit_ok  = !rsp_valid_ff || !rsp_stall;
      last_col = (col_ff + LEN_W'(1) == len_ff);
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      col_in       = col_ff;
      mean_in      = mean_ff;
      sq_in        = sq_ff;
      sumsq_in     = sumsq_ff;
      sqv_in       = sqv_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      step_in      = step_ff;
      inv_in       = inv_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      pplo_in      = pplo_ff;
      pphi_in      = pphi_ff;
      y_in         = y_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (buf_we) begin
               sum_in  = sum_ff + 22'(item.sample);
               fill_in = fill_next;
               if (fill_next >= n_len) begin
                  len_in   = fill_next;
                  state_in = ST_MEAN_GO;
               end
            end
         end
         ST_MEAN_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'({sum_abs, 8'b0}) + 64'(len_ff >> 1);
            div_req.divisor  = 32'(len_ff);
            state_in         = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               mean_in  = sum_ff[21] ? -$signed({1'b0, div_rsp.quotient[23:0]})
                                     : $signed({1'b0, div_rsp.quotient[23:0]});
               col_in   = '0;
               sumsq_in = '0;
               state_in = ST_VAR_RD;
            end
         end
         ST_VAR_RD: begin
            state_in = ST_VAR_SQ;
         end
         ST_VAR_SQ: begin
            sq_in    = d_mag * d_mag;
            state_in = ST_VAR_ACC;
         end
         ST_VAR_ACC: begin
            sumsq_in = sumsq_ff + 56'(sq_ff);
            if (last_col) begin
               state_in = ST_VAR_GO;
            end else begin
               col_in   = col_ff + LEN_W'(1);
               state_in = ST_VAR_RD;
            end
         end
         ST_VAR_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'(sumsq_ff);
            div_req.divisor  = 32'(len_ff);
            state_in         = ST_VAR_WAIT;
         end
         ST_VAR_WAIT: begin
            if (div_rsp.done) begin
               sqv_in   = 64'({ve, 12'b0});
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               step_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqv_ff >= trial) begin
               sqv_in = sqv_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = ST_INV_GO;
            end
         end
         ST_INV_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'd1 << 46;
            div_req.divisor  = s_fix;
            state_in         = ST_INV_WAIT;
         end
         ST_INV_WAIT: begin
            if (div_rsp.done) begin
               inv_in   = div_rsp.quotient[46:0];
               col_in   = '0;
               state_in = ST_OUT_RD;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_MAG;
         end
         ST_OUT_MAG: begin
            mag_in   = d_mag;
            neg_in   = d_val[25];
            state_in = ST_OUT_LO;
         end
         ST_OUT_LO: begin
            pplo_in  = mag_ff * inv_ff[23:0];
            state_in = ST_OUT_HI;
         end
         ST_OUT_HI: begin
            pphi_in  = mag_ff * inv_ff[46:24];
            state_in = ST_OUT_Y;
         end
         ST_OUT_Y: begin
            y_in     = 49'(gamma_rd_ff) * 49'(xh) + (49'(beta_rd_ff) <<< 16);
            state_in = ST_OUT_EMIT;
         end
         ST_OUT_EMIT: begin
            if (emit_ok) begin
               rsp_in.normalized = y_sat;
               rsp_in.out_column = col_ff[COL_W-1:0];
               rsp_in.row_end    = last_col;
               rsp_valid_in      = 1'b1;
               if (last_col) begin
                  sum_in   = '0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + LEN_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      col_ff   <= col_in;
      mean_ff  <= mean_in;
      sq_ff    <= sq_in;
      sumsq_ff <= sumsq_in;
      sqv_ff   <= sqv_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      step_ff  <= step_in;
      inv_ff   <= inv_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      pplo_ff  <= pplo_in;
      pphi_ff  <= pphi_in;
      y_ff     <= y_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Fill count never passes the buffer depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_W'(MAX_ROW))
      else $error("row fill count beyond buffer depth");

   // Divider is started only when free
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // Items are taken only while no row is in work
   assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (state_ff == ST_IDLE))
      else $error("item taken during row processing");

   // Emitting the last column flags row end and returns the core to idle, buffer empty
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_EMIT && emit_ok && last_col) |=>
         (rsp_valid_ff && rsp_ff.row_end && state_ff == ST_IDLE && fill_ff == '0))
      else $error("row end not followed by idle");

endmodule

// ----- rtl/layer_norm_row_engine_unit.sv -----
// ----------------------------------------------------------------------------
// layer_norm_row_engine_unit
// Layer-normalization forward over rows of Q8.8 samples with per-column
// Q4.12 gamma and beta tables.
//
//   channel | ports          | direction | payload
//   --------+----------------+-----------+---------------------------------
//   request | req_*          | in        | req_type: action, column, sample,
//           |                |           |           gamma_value, beta_value
//   result  | rsp_*          | out       | rsp_type: normalized, out_column,
//           |                |           |           row_end
//   config  | csr_*          | in        | row_length, epsilon
//
// Table and sample items leave the front queue at one per cycle while the back
// end is idle. Before the back end frees again, a completed row of n samples
// goes through three 64-step divider runs, a 32-step square root and the
// per-column variance and output loops over the row buffer.
// Reset is synchronous; it empties the queue and row state, tables are
// undefined until written. Each side stalls on its own: the queue absorbs
// items while the back end works, the output register holds a stalled result.
// ----------------------------------------------------------------------------
module layer_norm_row_engine_unit
   import lnr_pkg::*;
#(
   parameter int MAX_ROW = MAX_ROW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   logic    item_valid;
   logic    item_pop;
   req_type item;

   // Front queue
   lnr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_stall (req_stall),
      .push_data  (req_data),
      .pop_valid  (item_valid),
      .pop_en     (item_pop),
      .pop_data   (item)
   );

   // Back end
   lnr_core #(
      .MAX_ROW (MAX_ROW)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .item_valid   (item_valid),
      .item_pop     (item_pop),
      .item         (item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
